// File: hdl/slug_pkg.sv
// shared types, constants and helper functions of the slug stream normalizer
package slug_pkg;

	localparam logic [7:0] LEAD_BYTE     = 8'hC3;
	localparam logic [7:0] UML_A_LOWER   = 8'hA4;
	localparam logic [7:0] UML_A_UPPER   = 8'h84;
	localparam logic [7:0] UML_O_LOWER   = 8'hB6;
	localparam logic [7:0] UML_O_UPPER   = 8'h96;
	localparam logic [7:0] UML_U_LOWER   = 8'hBC;
	localparam logic [7:0] UML_U_UPPER   = 8'h9C;
	localparam logic [7:0] SHARP_S       = 8'h9F;
	localparam logic [7:0] CHAR_HYPHEN   = 8'h2D;
	localparam logic [7:0] CHAR_A        = 8'h61;
	localparam logic [7:0] CHAR_E        = 8'h65;
	localparam logic [7:0] CHAR_O        = 8'h6F;
	localparam logic [7:0] CHAR_U        = 8'h75;
	localparam logic [7:0] CHAR_S        = 8'h73;
	localparam logic [7:0] CASE_OFFSET   = 8'h20;
	localparam logic [7:0] MAX_LEN_RESET = 8'd60;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam int FALLBACK_LEN = 8;
	localparam int FB_IW        = $clog2(FALLBACK_LEN);

	// slug bytes and end handling for one accepted request
	typedef struct packed {
		logic [1:0]      n_bytes;
		logic [2:0][7:0] bytes;
		logic            fin;
		logic            untitled;
		logic            close_mark;
	} cmd_t;

	// running slug state plus bytes gathered in the current request
	typedef struct packed {
		logic            lp;
		logic            sp;
		logic [7:0]      cnt;
		logic            lim;
		logic [1:0]      n;
		logic [2:0][7:0] b;
	} work_t;

	function automatic logic [7:0] fallback_char(logic [FB_IW-1:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h75;
			3'd1: c = 8'h6E;
			3'd2: c = 8'h74;
			3'd3: c = 8'h69;
			3'd4: c = 8'h74;
			3'd5: c = 8'h6C;
			3'd6: c = 8'h65;
			3'd7: c = 8'h64;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// first letter in high byte, second in low byte, zero if no umlaut
	function automatic logic [15:0] umlaut_pair(logic [7:0] b);
		logic [15:0] r;
		case (b)
			UML_A_LOWER, UML_A_UPPER: r = {CHAR_A, CHAR_E};
			UML_O_LOWER, UML_O_UPPER: r = {CHAR_O, CHAR_E};
			UML_U_LOWER, UML_U_UPPER: r = {CHAR_U, CHAR_E};
			SHARP_S:                  r = {CHAR_S, CHAR_S};
			default:                  r = 16'h0000;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/slug_front.sv
// front end: accepts title bytes, tracks slug state and builds output commands
module slug_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [7:0]           cfg_wr_data,
	input  logic                 in_fire,
	input  logic [7:0]           in_byte,
	input  logic                 in_flag,
	input  logic                 in_end,
	output logic                 push,
	output slug_pkg::cmd_t       cmd
);

	logic [7:0]     max_len_q;
	logic           lp_q;
	logic           sp_q;
	logic [7:0]     cnt_q;
	logic           lim_q;
	slug_pkg::work_t w_c;
	logic [15:0]    pair_c;
	logic           handled_c;

	function automatic slug_pkg::work_t take_char(slug_pkg::work_t w, logic [7:0] c,
			logic [7:0] mx);
		slug_pkg::work_t r;
		r = w;
		if (!r.lim) begin
			if (r.sp && (r.cnt < mx)) begin
				r.b[r.n] = slug_pkg::CHAR_HYPHEN;
				r.n      = r.n + 2'd1;
				r.cnt    = r.cnt + 8'd1;
				r.sp     = 1'b0;
			end
			if (r.cnt >= mx) begin
				r.lim = 1'b1;
			end else begin
				r.b[r.n] = c;
				r.n      = r.n + 2'd1;
				r.cnt    = r.cnt + 8'd1;
			end
		end
		return r;
	endfunction

	function automatic slug_pkg::work_t take_sep(slug_pkg::work_t w);
		slug_pkg::work_t r;
		r = w;
		if (!r.lim) begin
			r.sp = (r.cnt != 8'd0);
		end
		return r;
	endfunction

	assign pair_c = slug_pkg::umlaut_pair(in_byte);

	always_comb begin
		w_c       = '{lp: lp_q, sp: sp_q, cnt: cnt_q, lim: lim_q, n: 2'd0, b: '0};
		handled_c = 1'b0;
		if (in_flag) begin
			if (w_c.lp) begin
				w_c.lp = 1'b0;
				if (pair_c[15:8] != 8'd0) begin
					w_c       = take_char(w_c, pair_c[15:8], max_len_q);
					w_c       = take_char(w_c, pair_c[7:0], max_len_q);
					handled_c = 1'b1;
				end else begin
					w_c = take_sep(w_c);
				end
			end
			if (!handled_c) begin
				if (in_byte == slug_pkg::LEAD_BYTE) begin
					w_c.lp = 1'b1;
				end else if (in_byte inside {[8'h41:8'h5A]}) begin
					w_c = take_char(w_c, in_byte + slug_pkg::CASE_OFFSET, max_len_q);
				end else if (in_byte inside {[8'h61:8'h7A], [8'h30:8'h39]}) begin
					w_c = take_char(w_c, in_byte, max_len_q);
				end else begin
					w_c = take_sep(w_c);
				end
			end
		end
		if (in_end && w_c.lp) begin
			w_c.lp = 1'b0;
			w_c    = take_sep(w_c);
		end
	end

	always_comb begin
		cmd.n_bytes    = w_c.n;
		cmd.bytes      = w_c.b;
		cmd.fin        = in_end;
		cmd.untitled   = in_end && (w_c.cnt == 8'd0);
		cmd.close_mark = in_end && (w_c.cnt != 8'd0) && (w_c.n == 2'd0);
		push           = in_fire && ((w_c.n != 2'd0) || in_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= slug_pkg::MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q  <= 1'b0;
			sp_q  <= 1'b0;
			cnt_q <= 8'd0;
			lim_q <= 1'b0;
		end else if (in_fire) begin
			if (in_end) begin
				lp_q  <= 1'b0;
				sp_q  <= 1'b0;
				cnt_q <= 8'd0;
				lim_q <= 1'b0;
			end else begin
				lp_q  <= w_c.lp;
				sp_q  <= w_c.sp;
				cnt_q <= w_c.cnt;
				lim_q <= w_c.lim;
			end
		end
	end

endmodule

// File: hdl/slug_fifo.sv
// small command queue between front and back end
module slug_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  slug_pkg::cmd_t wr_data,
	input  logic           rd_en,
	output slug_pkg::cmd_t rd_data,
	output logic           empty,
	output logic           full
);

	slug_pkg::cmd_t                 mem_q [slug_pkg::FIFO_DEPTH];
	logic [slug_pkg::FIFO_AW-1:0]   wr_ptr_q;
	logic [slug_pkg::FIFO_AW-1:0]   rd_ptr_q;
	logic [slug_pkg::FIFO_AW:0]     count_q;
	logic                           do_wr;
	logic                           do_rd;

	assign empty   = (count_q == '0);
	assign full    = (count_q == (slug_pkg::FIFO_AW+1)'(slug_pkg::FIFO_DEPTH));
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + (slug_pkg::FIFO_AW)'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + (slug_pkg::FIFO_AW)'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (slug_pkg::FIFO_AW+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (slug_pkg::FIFO_AW+1)'(1);
			end
		end
	end

endmodule

// File: hdl/slug_back.sv
// back end: expands queued commands into slug bytes, one per cycle while the output is taken
module slug_back (
	input  logic           clk,
	input  logic           arst_n,
	input  slug_pkg::cmd_t cmd,
	input  logic           cmd_avail,
	output logic           pop,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [7:0]     m_axis_tdata,
	output logic           m_axis_tuser,
	output logic           m_axis_tlast
);

	logic [2:0] idx_q;
	logic [3:0] total_c;
	logic       step_c;
	logic       at_end_c;
	logic [7:0] byte_c;
	logic       flag_c;
	logic       last_c;
	logic       vld_q;
	logic [7:0] byte_q;
	logic       flag_q;
	logic       last_q;

	always_comb begin
		if (cmd.untitled) begin
			total_c = 4'(slug_pkg::FALLBACK_LEN);
		end else begin
			total_c = {2'b00, cmd.n_bytes} + {3'b000, cmd.close_mark};
		end
		at_end_c = ({1'b0, idx_q} == total_c - 4'd1);
		step_c   = cmd_avail && (!vld_q || m_axis_tready);
		pop      = step_c && at_end_c;
		if (cmd.untitled) begin
			byte_c = slug_pkg::fallback_char(idx_q);
			flag_c = 1'b1;
			last_c = at_end_c;
		end else if ({1'b0, idx_q} < {2'b00, cmd.n_bytes}) begin
			byte_c = cmd.bytes[idx_q[1:0]];
			flag_c = 1'b1;
			last_c = cmd.fin && at_end_c;
		end else begin
			byte_c = 8'd0;
			flag_c = 1'b0;
			last_c = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (step_c) begin
				idx_q <= at_end_c ? 3'd0 : idx_q + 3'd1;
				vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_c) begin
			byte_q <= byte_c;
			flag_q <= flag_c;
			last_q <= last_c;
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata  = byte_q;
	assign m_axis_tuser  = flag_q;
	assign m_axis_tlast  = last_q;

endmodule

// File: hdl/slug_stream_normalizer.sv
// top level of the slug stream normalizer
// Turns a title, one byte per request, into a URL slug. The input side takes
// one request per cycle while the four-entry command queue has room; each byte
// becomes zero to three slug bytes (hyphen plus umlaut pair), an end marker may
// add a closing marker, and an empty slug becomes the eight bytes of untitled.
// The output register sends one slug byte per cycle while the receiver is
// ready, so the sustained rate is set by how many slug bytes each request
// yields. The input stalls only while the queue is full. The first slug byte
// of a request passes through the command queue and then the output register.
// The user must write the slug length limit through cfg_wr_en only while no
// title is in flight; the block itself does not enforce this.
module slug_stream_normalizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // byte_value
	input  logic       s_axis_tuser,  // in_valid
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // out_byte
	output logic       m_axis_tuser,  // out_valid
	output logic       m_axis_tlast
);

	logic           fifo_full;
	logic           fifo_empty;
	logic           push;
	logic           pop;
	logic           in_fire;
	slug_pkg::cmd_t wr_cmd;
	slug_pkg::cmd_t rd_cmd;

	assign s_axis_tready = !fifo_full;
	assign in_fire       = s_axis_tvalid && !fifo_full;

	slug_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_fire     (in_fire),
		.in_byte     (s_axis_tdata),
		.in_flag     (s_axis_tuser),
		.in_end      (s_axis_tlast),
		.push        (push),
		.cmd         (wr_cmd)
	);

	slug_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (wr_cmd),
		.rd_en   (pop),
		.rd_data (rd_cmd),
		.empty   (fifo_empty),
		.full    (fifo_full)
	);

	slug_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (rd_cmd),
		.cmd_avail     (!fifo_empty),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// File: sim/slug_checker.sv
// slug checker: predicts the slug bytes of each accepted request and compares the output stream
module slug_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // byte_value
	input  logic       s_axis_tuser,  // in_valid
	input  logic       s_axis_tlast,
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,  // out_byte
	input  logic       m_axis_tuser,  // out_valid
	input  logic       m_axis_tlast,
	output int         error_count,
	output int         pending_count
);

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
	} slug_out_t;

	localparam logic [63:0] UNTITLED_TEXT = "untitled";

	slug_out_t  expected_slug[$];
	slug_out_t  step_out[$];
	slug_out_t  got;
	slug_out_t  want;
	logic [7:0] max_len;
	logic [7:0] slug_len;
	logic       lead_held;
	logic       hyphen_owed;
	logic       capped;

	function automatic void add_out(slug_out_t e);
		step_out.insert(step_out.size(), e);
	endfunction

	function automatic void clear_title();
		lead_held   = 1'b0;
		hyphen_owed = 1'b0;
		slug_len    = 8'd0;
		capped      = 1'b0;
	endfunction

	function automatic void note_separator();
		if (!capped)
			hyphen_owed = (slug_len != 8'd0);
	endfunction

	function automatic void add_char(logic [7:0] c);
		if (capped)
			return;
		if (hyphen_owed && slug_len < max_len) begin
			add_out(slug_out_t'{slug_pkg::CHAR_HYPHEN, 1'b1, 1'b0});
			slug_len++;
			hyphen_owed = 1'b0;
		end
		if (slug_len >= max_len) begin
			capped = 1'b1;
			return;
		end
		add_out(slug_out_t'{c, 1'b1, 1'b0});
		slug_len++;
	endfunction

	function automatic void take_title_byte(logic [7:0] b);
		logic [7:0] first;
		logic [7:0] second;
		first  = 8'd0;
		second = 8'd0;
		if (lead_held) begin
			lead_held = 1'b0;
			case (b)
				slug_pkg::UML_A_LOWER, slug_pkg::UML_A_UPPER: begin
					first  = slug_pkg::CHAR_A;
					second = slug_pkg::CHAR_E;
				end
				slug_pkg::UML_O_LOWER, slug_pkg::UML_O_UPPER: begin
					first  = slug_pkg::CHAR_O;
					second = slug_pkg::CHAR_E;
				end
				slug_pkg::UML_U_LOWER, slug_pkg::UML_U_UPPER: begin
					first  = slug_pkg::CHAR_U;
					second = slug_pkg::CHAR_E;
				end
				slug_pkg::SHARP_S: begin
					first  = slug_pkg::CHAR_S;
					second = slug_pkg::CHAR_S;
				end
				default: first = 8'd0;
			endcase
			if (first != 8'd0) begin
				add_char(first);
				add_char(second);
				return;
			end
			note_separator();
		end
		if (b == slug_pkg::LEAD_BYTE)
			lead_held = 1'b1;
		else if (b >= "A" && b <= "Z")
			add_char(b + slug_pkg::CASE_OFFSET);
		else if ((b >= "a" && b <= "z") || (b >= "0" && b <= "9"))
			add_char(b);
		else
			note_separator();
	endfunction

	function automatic void predict_request(logic [7:0] b, logic v, logic l);
		step_out.delete();
		if (v)
			take_title_byte(b);
		if (l) begin
			if (lead_held) begin
				lead_held = 1'b0;
				note_separator();
			end
			if (slug_len == 8'd0) begin
				for (int i = 0; i < 8; i++)
					add_out(slug_out_t'{UNTITLED_TEXT[8*(7-i) +: 8], 1'b1, (i == 7)});
			end else if (step_out.size() > 0) begin
				step_out[step_out.size() - 1].last = 1'b1;
			end else begin
				add_out(slug_out_t'{8'd0, 1'b0, 1'b1});
			end
			clear_title();
		end
		foreach (step_out[i])
			expected_slug.insert(expected_slug.size(), step_out[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len = slug_pkg::MAX_LEN_RESET;
			clear_title();
			expected_slug.delete();
			pending_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata, m_axis_tuser, m_axis_tlast};
				if (expected_slug.size() == 0) begin
					$display("%0t: expected nothing, got %h/%b/%b",
						$time, got.data, got.valid, got.last);
					error_count++;
				end else begin
					want = expected_slug.pop_front();
					if (got.data !== want.data || got.valid !== want.valid
							|| got.last !== want.last) begin
						$display("%0t: expected %h/%b/%b, got %h/%b/%b",
							$time, want.data, want.valid, want.last,
							got.data, got.valid, got.last);
						error_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_request(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (cfg_wr_en)
				max_len = cfg_wr_data;
			pending_count = expected_slug.size();
		end
	end

endmodule

// File: sim/slug_stream_normalizer_test.sv
// testbench top: drives titles and limit writes into the slug normalizer and reports the verdict
module slug_stream_normalizer_test;

	typedef struct packed {
		logic [7:0] data;
		logic       user;
		logic       last;
	} title_req_t;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_REQS  = 33;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;  // byte_value
	logic       s_axis_tuser;  // in_valid
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;  // out_byte
	logic       m_axis_tuser;  // out_valid
	logic       m_axis_tlast;

	int error_count;
	int pending_count;
	int cycle_count = 0;
	int burst_left = 0;
	int phase_sent;
	int hold_asked = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int stall_left = 0;

	title_req_t title_q[$];
	logic [7:0] limit_steps[6] = '{8'd1, 8'd255, 8'd3, 8'd60, 8'd17, 8'd2};

	slug_stream_normalizer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	slug_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: long hold-offs on demand, otherwise phases of free, random and heavy stall
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_taken != hold_asked) begin
			hold_taken = hold_asked;
			hold_left  = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(5, 60);
			end
			stall_left--;
			case (stall_mode)
				0:       m_axis_tready <= 1'b1;
				1:       m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	task automatic push_byte(logic [7:0] data, logic user, logic last);
		title_q.insert(title_q.size(), title_req_t'{data, user, last});
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], 1'b1, 1'b0);
	endtask

	task automatic offer_request(title_req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= r.data;
		s_axis_tuser  <= r.user;
		s_axis_tlast  <= r.last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic send_title();
		foreach (title_q[i]) begin
			offer_request(title_q[i]);
			if (title_q[i].user || title_q[i].last)
				phase_sent++;
		end
		title_q.delete();
	endtask

	// sender pause until every slug byte is out, plus the block's own latency
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_limit(logic [7:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic logic [7:0] pick_umlaut();
		case ($urandom_range(0, 6))
			0:       return slug_pkg::UML_A_LOWER;
			1:       return slug_pkg::UML_A_UPPER;
			2:       return slug_pkg::UML_O_LOWER;
			3:       return slug_pkg::UML_O_UPPER;
			4:       return slug_pkg::UML_U_LOWER;
			5:       return slug_pkg::UML_U_UPPER;
			default: return slug_pkg::SHARP_S;
		endcase
	endfunction

	function automatic logic [7:0] pick_separator();
		case ($urandom_range(0, 5))
			0:       return " ";
			1:       return "-";
			2:       return ".";
			3:       return "_";
			4:       return 8'h7F;
			default: return 8'h00;
		endcase
	endfunction

	task automatic make_title();
		int n;
		int pick;
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 38)
				push_byte(8'($urandom_range(0, 1) ? $urandom_range(65, 90)
					: $urandom_range(97, 122)), 1'b1, 1'b0);
			else if (pick < 52)
				push_byte(8'($urandom_range(48, 57)), 1'b1, 1'b0);
			else if (pick < 68) begin
				push_byte(slug_pkg::LEAD_BYTE, 1'b1, 1'b0);
				push_byte(pick_umlaut(), 1'b1, 1'b0);
			end else if (pick < 78)
				push_byte(pick_separator(), 1'b1, 1'b0);
			else if (pick < 83)
				push_byte(slug_pkg::LEAD_BYTE, 1'b1, 1'b0);
			else if (pick < 94)
				push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
			else
				push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		end
		if (title_q.size() > 0 && $urandom_range(0, 9) < 7) begin
			title_q[title_q.size() - 1].last = 1'b1;
		end else begin
			push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = 8'd0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'd0;
		s_axis_tuser  = 1'b0;
		s_axis_tlast  = 1'b0;
		phase_sent    = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty title
		push_byte(8'hA5, 1'b0, 1'b1);
		// field extremes, closing marker after a trailing separator
		push_byte(8'h00, 1'b1, 1'b0);
		push_text("Z9");
		push_byte(8'hFF, 1'b1, 1'b0);
		push_byte("a", 1'b1, 1'b0);
		push_byte(8'h80, 1'b1, 1'b1);
		// umlauts, lead without umlaut, lead at end of title
		push_byte(slug_pkg::LEAD_BYTE, 1'b1, 1'b0);
		push_byte(slug_pkg::SHARP_S, 1'b1, 1'b0);
		push_byte(slug_pkg::LEAD_BYTE, 1'b1, 1'b0);
		push_byte(slug_pkg::UML_A_UPPER, 1'b1, 1'b0);
		push_byte("_", 1'b1, 1'b0);
		push_byte(slug_pkg::LEAD_BYTE, 1'b1, 1'b0);
		push_byte(slug_pkg::LEAD_BYTE, 1'b1, 1'b0);
		push_byte(slug_pkg::UML_O_LOWER, 1'b1, 1'b0);
		push_byte("q", 1'b1, 1'b0);
		push_byte(slug_pkg::LEAD_BYTE, 1'b1, 1'b1);
		// bare requests: ignored one, then end marker after a word
		push_byte(8'hFF, 1'b0, 1'b0);
		push_text("0");
		push_byte(8'h00, 1'b0, 1'b1);
		// separators only
		push_byte("#", 1'b1, 1'b1);
		send_title();
		drain();

		// hyphen fills the limit, umlaut pair cut at the limit
		write_limit(8'd2);
		push_text("a b");
		push_byte(slug_pkg::SHARP_S, 1'b1, 1'b0);
		title_q[2].last = 1'b1;
		title_q.pop_back();
		push_text("x");
		push_byte(slug_pkg::LEAD_BYTE, 1'b1, 1'b0);
		push_byte(slug_pkg::SHARP_S, 1'b1, 1'b1);
		send_title();
		drain();

		foreach (limit_steps[p]) begin
			write_limit(limit_steps[p]);
			if (p == 1 || p == 4)
				hold_asked++;
			phase_sent = 0;
			while (phase_sent < PHASE_REQS) begin
				make_title();
				send_title();
			end
			drain();
		end

		repeat (20) @(negedge clk);
		if (error_count == 0 && pending_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
